// ----- design/uvs_pkg.sv -----
// ============================================================================
// uvs_pkg: shared types, constants and the sine table of the UV sphere
// vertex generator. The table holds one quarter wave of sine in Q1.15.
// ============================================================================
package uvs_pkg;

  // Sizing of the grid and the angle arithmetic.
  localparam int MAX_DIVISIONS    = 64;
  localparam int ANGLE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  // Field widths.
  localparam int CNT_W    = 7;
  localparam int RADIUS_W = 16;
  localparam int POS_W    = 17;
  localparam int MAG_W    = POS_W - 1;
  localparam int VIDX_W   = 13;
  localparam int LIN_W    = 2 * CNT_W + 1;
  localparam int SINE_W   = 16;

  // Lower bounds of a usable configuration.
  localparam int MIN_SLICES = 3;
  localparam int MIN_STACKS = 2;

  // Reset values of the configuration registers.
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(256);
  localparam logic [CNT_W-1:0]    SLICES_RST = CNT_W'(16);
  localparam logic [CNT_W-1:0]    STACKS_RST = CNT_W'(8);

  // Angle divider: restoring division, several quotient bits per stage.
  localparam int NUM_W      = CNT_W + ANGLE_BITS + 1;
  localparam int DEN_W      = CNT_W + 1;
  localparam int REM_W      = CNT_W + 2;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (ANGLE_BITS + 2 + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QUOT_W     = DIV_STAGES * DIV_STEPS;

  // Sine lookup.
  localparam int FRAC_W = ANGLE_BITS - 2;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int LK_W   = FRAC_W + IDX_W + 1;

  // Product widths and rounding shifts.
  localparam int PAIR_W = 2 * SINE_W;
  localparam int PX_W   = RADIUS_W + PAIR_W;
  localparam int SC3_SH = 2 * (SINE_W - 1);
  localparam int SC2_SH = SINE_W - 1;

  // Pipeline positions.
  localparam int ST_IDX     = DIV_STAGES + 1;
  localparam int PIPE_DEPTH = DIV_STAGES + 6;

  // Bus widths.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USER_W = 3;

  // Register map, one register every four bytes.
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_SLICES = 2'd1,
    REG_STACKS = 2'd2
  } reg_idx_e;

  // Input word, stack number in the low bits.
  typedef struct packed {
    logic [IN_DATA_W-2*CNT_W-1:0] pad;
    logic [CNT_W-1:0]             slice_number;
    logic [CNT_W-1:0]             stack_number;
  } in_data_t;

  // Output word, pos_x in the low bits.
  typedef struct packed {
    logic [OUT_DATA_W-3*POS_W-5*VIDX_W-1:0] pad;
    logic [VIDX_W-1:0] corner_d;
    logic [VIDX_W-1:0] corner_c;
    logic [VIDX_W-1:0] corner_b;
    logic [VIDX_W-1:0] corner_a;
    logic [VIDX_W-1:0] vertex_number;
    logic [POS_W-1:0]  pos_z;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
  } out_data_t;

  // Output flags, vertex_valid in bit 0.
  typedef struct packed {
    logic config_error;
    logic cell_valid;
    logic vertex_valid;
  } out_user_t;

  // Index and flag fields that ride along the pipeline.
  typedef struct packed {
    logic              vertex_valid;
    logic              cell_valid;
    logic              config_error;
    logic [VIDX_W-1:0] vertex_number;
    logic [VIDX_W-1:0] corner_a;
    logic [VIDX_W-1:0] corner_b;
    logic [VIDX_W-1:0] corner_c;
    logic [VIDX_W-1:0] corner_d;
  } side_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  // Pi in Q30.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // One Taylor term divided by (2k)(2k+1), rounded.
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
    case (k)
      1:       return (t + 64'd3) / 64'd6;
      2:       return (t + 64'd10) / 64'd20;
      3:       return (t + 64'd21) / 64'd42;
      4:       return (t + 64'd36) / 64'd72;
      5:       return (t + 64'd55) / 64'd110;
      6:       return (t + 64'd78) / 64'd156;
      7:       return (t + 64'd105) / 64'd210;
      8:       return (t + 64'd136) / 64'd272;
      9:       return (t + 64'd171) / 64'd342;
      default: return (t + 64'd210) / 64'd420;
    endcase
  endfunction

  // Sine of a Q30 angle in the first quadrant, as Q15 clamped to [0, 1.0].
  function automatic logic [SINE_W-1:0] taylor_sine_q15(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 10; k++) begin
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = taylor_div(term, k);
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) begin
      sum = 64'sd32768;
    end
    return sum[SINE_W-1:0];
  endfunction

  // Quarter-wave table, entry i is sin(i*pi/(2*depth)).
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (64'(i) * PI_Q30 + 64'(SINE_TABLE_DEPTH)) / 64'(2 * SINE_TABLE_DEPTH);
      rom[i] = taylor_sine_q15(x);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- design/uv_sphere_vertex_index_generator.sv -----
// ============================================================================
// uv_sphere_vertex_index_generator: grid point generator of a UV sphere
// Turns a (stack, slice) pair into a vertex position, its linear index and
// the corner indices of the grid cell that starts there.
// ============================================================================
// Usage:
// Each s_axis word carries one stack number and one slice number. Each
// m_axis word returns the vertex in Q8.8, its linear index, the four cell
// corners and three flags in tuser. Radius, slice count and stack count must
// be written over the APB port while no word is in flight; nothing enforces it.
// Throughput is one word per cycle while not stalled. From acceptance to
// m_axis_tvalid: one capture stage, a six-stage restoring divider that forms
// both angles three quotient bits a stage, the table index stage, the
// registered sine table read, two multiplier stages and the output register.
// Reset empties the pipeline and loads radius 1.0, 16 slices and 8 stacks;
// the sine table is constant, so there is no clearing pass.
// When a word waits at the output and m_axis_tready is low, the whole
// pipeline holds and s_axis_tready falls; while the output register is empty
// s_axis_tready stays high and the pipeline keeps moving.
// ============================================================================
module uv_sphere_vertex_index_generator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [uvs_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [uvs_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [uvs_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  // Input stream: stack_number [6:0], slice_number [13:7], zeros above
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [uvs_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // Output stream: pos_x, pos_y, pos_z, vertex_number, corner_a, corner_b,
  // corner_c, corner_d from bit 0 up, zeros above
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [uvs_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // tuser: vertex_valid [0], cell_valid [1], config_error [2]
  output logic [uvs_pkg::OUT_USER_W-1:0]        m_axis_tuser
);

  // Lanes of the sine lookup.
  localparam int LANE_SP = 0;
  localparam int LANE_CP = 1;
  localparam int LANE_ST = 2;
  localparam int LANE_CT = 3;

  localparam logic [uvs_pkg::ANGLE_BITS-1:0] QUARTER =
    uvs_pkg::ANGLE_BITS'(1 << (uvs_pkg::ANGLE_BITS - 2));

  // Configuration registers.
  logic [uvs_pkg::RADIUS_W-1:0] radius_q;
  logic [uvs_pkg::CNT_W-1:0]    slice_count_q;
  logic [uvs_pkg::CNT_W-1:0]    stack_count_q;

  // Pipeline control.
  logic                         adv;
  logic                         vld_q [uvs_pkg::PIPE_DEPTH];
  uvs_pkg::side_t               side_q [uvs_pkg::PIPE_DEPTH];
  uvs_pkg::side_t               side_in;

  // Capture stage.
  uvs_pkg::in_data_t            in_data;
  logic [uvs_pkg::CNT_W-1:0]    slices_sat;
  logic [uvs_pkg::CNT_W-1:0]    stacks_sat;
  logic                         cfg_err;
  logic [uvs_pkg::DEN_W-1:0]    row_len;
  logic [uvs_pkg::LIN_W-1:0]    lin_a;
  logic [uvs_pkg::LIN_W-1:0]    lin_c;
  logic [uvs_pkg::NUM_W-1:0]    num [2];
  logic [uvs_pkg::DEN_W-1:0]    den [2];

  // Divider lanes: 0 is latitude, 1 is longitude.
  logic [uvs_pkg::REM_W-1:0]    rem_q [uvs_pkg::DIV_STAGES][2];
  logic [uvs_pkg::REM_W-1:0]    rem_d [uvs_pkg::DIV_STAGES][2];
  logic [uvs_pkg::QUOT_W-1:0]   sh_q  [uvs_pkg::DIV_STAGES+1][2];
  logic [uvs_pkg::QUOT_W-1:0]   sh_d  [uvs_pkg::DIV_STAGES][2];

  // Lookup and multiply stages.
  logic [uvs_pkg::ANGLE_BITS-1:0] angle [4];
  logic [uvs_pkg::IDX_W-1:0]    idx_d [4];
  logic [uvs_pkg::IDX_W-1:0]    idx_q [4];
  logic                         neg_q [4];
  logic [uvs_pkg::SINE_W-1:0]   sine_q [4];
  logic                         sneg_q [4];
  logic [uvs_pkg::PAIR_W-1:0]   pxc_q;
  logic [uvs_pkg::PAIR_W-1:0]   pzc_q;
  logic [uvs_pkg::PAIR_W-1:0]   py_q;
  logic                         negx1_q, negy1_q, negz1_q;
  logic [uvs_pkg::PX_W-1:0]     prodx_q;
  logic [uvs_pkg::PX_W-1:0]     prodz_q;
  logic [uvs_pkg::MAG_W-1:0]    magy_q;
  logic                         negx2_q, negy2_q, negz2_q;
  logic [uvs_pkg::PAIR_W:0]     sum_y;
  logic [uvs_pkg::PX_W:0]       sum_x;
  logic [uvs_pkg::PX_W:0]       sum_z;
  logic [uvs_pkg::POS_W-1:0]    pos_x_d, pos_y_d, pos_z_d;
  logic [uvs_pkg::POS_W-1:0]    pos_x_q, pos_y_q, pos_z_q;

  uvs_pkg::out_data_t           out_data;
  uvs_pkg::out_user_t           out_user;

  // APB: always ready, registers written in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= uvs_pkg::RADIUS_RST;
      slice_count_q <= uvs_pkg::SLICES_RST;
      stack_count_q <= uvs_pkg::STACKS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        uvs_pkg::REG_RADIUS: radius_q      <= pwdata[uvs_pkg::RADIUS_W-1:0];
        uvs_pkg::REG_SLICES: slice_count_q <= pwdata[uvs_pkg::CNT_W-1:0];
        uvs_pkg::REG_STACKS: stack_count_q <= pwdata[uvs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      uvs_pkg::REG_RADIUS: prdata = uvs_pkg::APB_DATA_W'(radius_q);
      uvs_pkg::REG_SLICES: prdata = uvs_pkg::APB_DATA_W'(slice_count_q);
      uvs_pkg::REG_STACKS: prdata = uvs_pkg::APB_DATA_W'(stack_count_q);
      default:             prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign adv           = !vld_q[uvs_pkg::PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;

  // Saturated counts and divisors; user holds them while words are in flight.
  always_comb begin
    slices_sat = (slice_count_q > uvs_pkg::CNT_W'(uvs_pkg::MAX_DIVISIONS)) ?
                 uvs_pkg::CNT_W'(uvs_pkg::MAX_DIVISIONS) : slice_count_q;
    stacks_sat = (stack_count_q > uvs_pkg::CNT_W'(uvs_pkg::MAX_DIVISIONS)) ?
                 uvs_pkg::CNT_W'(uvs_pkg::MAX_DIVISIONS) : stack_count_q;
    cfg_err    = (slice_count_q < uvs_pkg::CNT_W'(uvs_pkg::MIN_SLICES)) ||
                 (stack_count_q < uvs_pkg::CNT_W'(uvs_pkg::MIN_STACKS));
    den[0]     = {stacks_sat, 1'b0};
    den[1]     = {slices_sat, 1'b0};
  end

  // Capture stage: flags, linear indices and rounded angle numerators.
  always_comb begin
    in_data = uvs_pkg::in_data_t'(s_axis_tdata);
    row_len = uvs_pkg::DEN_W'(slices_sat) + uvs_pkg::DEN_W'(1);
    lin_a   = uvs_pkg::LIN_W'(in_data.stack_number) * uvs_pkg::LIN_W'(row_len) +
              uvs_pkg::LIN_W'(in_data.slice_number);
    lin_c   = lin_a + uvs_pkg::LIN_W'(row_len);

    side_in.config_error = cfg_err;
    side_in.vertex_valid = !cfg_err && (in_data.stack_number <= stacks_sat) &&
                           (in_data.slice_number <= slices_sat);
    side_in.cell_valid   = !cfg_err && (in_data.stack_number < stacks_sat) &&
                           (in_data.slice_number < slices_sat);

    side_in.vertex_number = side_in.vertex_valid ? lin_a[uvs_pkg::VIDX_W-1:0] : '0;
    if (side_in.cell_valid) begin
      side_in.corner_a = lin_a[uvs_pkg::VIDX_W-1:0];
      side_in.corner_b = lin_a[uvs_pkg::VIDX_W-1:0] + uvs_pkg::VIDX_W'(1);
      side_in.corner_c = lin_c[uvs_pkg::VIDX_W-1:0];
      side_in.corner_d = lin_c[uvs_pkg::VIDX_W-1:0] + uvs_pkg::VIDX_W'(1);
    end else begin
      side_in.corner_a = '0;
      side_in.corner_b = '0;
      side_in.corner_c = '0;
      side_in.corner_d = '0;
    end

    // phi = (stack*2^A + stacks) / (2*stacks), theta likewise over a full turn.
    num[0] = uvs_pkg::NUM_W'({in_data.stack_number, {uvs_pkg::ANGLE_BITS{1'b0}}}) +
             uvs_pkg::NUM_W'(stacks_sat);
    num[1] = uvs_pkg::NUM_W'({in_data.slice_number,
                              {(uvs_pkg::ANGLE_BITS + 1){1'b0}}}) +
             uvs_pkg::NUM_W'(slices_sat);
  end

  // Divider stages: each step shifts in one numerator bit, subtracts when it fits.
  always_comb begin
    logic [uvs_pkg::REM_W-1:0]  r;
    logic [uvs_pkg::QUOT_W-1:0] sh;
    logic                       ge;
    for (int s = 0; s < uvs_pkg::DIV_STAGES; s++) begin
      for (int l = 0; l < 2; l++) begin
        r  = rem_q[s][l];
        sh = sh_q[s][l];
        for (int t = 0; t < uvs_pkg::DIV_STEPS; t++) begin
          r  = {r[uvs_pkg::REM_W-2:0], sh[uvs_pkg::QUOT_W-1]};
          ge = (r >= {1'b0, den[l]});
          if (ge) begin
            r = r - {1'b0, den[l]};
          end
          sh = {sh[uvs_pkg::QUOT_W-2:0], ge};
        end
        rem_d[s][l] = r;
        sh_d[s][l]  = sh;
      end
    end
  end

  // Table index: nearest entry, mirrored in odd quadrants.
  always_comb begin
    logic [uvs_pkg::LK_W-1:0] lk;
    logic [uvs_pkg::LK_W-1:0] raw;
    logic [uvs_pkg::IDX_W-1:0] id;
    angle[LANE_SP] = sh_q[uvs_pkg::DIV_STAGES][0][uvs_pkg::ANGLE_BITS-1:0];
    angle[LANE_CP] = angle[LANE_SP] + QUARTER;
    angle[LANE_ST] = sh_q[uvs_pkg::DIV_STAGES][1][uvs_pkg::ANGLE_BITS-1:0];
    angle[LANE_CT] = angle[LANE_ST] + QUARTER;
    for (int k = 0; k < 4; k++) begin
      lk  = uvs_pkg::LK_W'(angle[k][uvs_pkg::FRAC_W-1:0]) *
            uvs_pkg::LK_W'(uvs_pkg::SINE_TABLE_DEPTH) +
            uvs_pkg::LK_W'(1 << (uvs_pkg::ANGLE_BITS - 3));
      raw = lk >> uvs_pkg::FRAC_W;
      if (raw > uvs_pkg::LK_W'(uvs_pkg::SINE_TABLE_DEPTH)) begin
        id = uvs_pkg::IDX_W'(uvs_pkg::SINE_TABLE_DEPTH);
      end else begin
        id = raw[uvs_pkg::IDX_W-1:0];
      end
      if (angle[k][uvs_pkg::ANGLE_BITS-2]) begin
        id = uvs_pkg::IDX_W'(uvs_pkg::SINE_TABLE_DEPTH) - id;
      end
      idx_d[k] = id;
    end
  end

  // Output rounding: magnitude rounded half up, sign applied, zero off the grid.
  always_comb begin
    logic [uvs_pkg::MAG_W-1:0] mx;
    logic [uvs_pkg::MAG_W-1:0] mz;
    sum_x = {1'b0, prodx_q} + (uvs_pkg::PX_W + 1)'(1 << (uvs_pkg::SC3_SH - 1));
    sum_z = {1'b0, prodz_q} + (uvs_pkg::PX_W + 1)'(1 << (uvs_pkg::SC3_SH - 1));
    mx    = sum_x[uvs_pkg::SC3_SH +: uvs_pkg::MAG_W];
    mz    = sum_z[uvs_pkg::SC3_SH +: uvs_pkg::MAG_W];
    pos_x_d = negx2_q ? -uvs_pkg::POS_W'(mx) : uvs_pkg::POS_W'(mx);
    pos_y_d = negy2_q ? -uvs_pkg::POS_W'(magy_q) : uvs_pkg::POS_W'(magy_q);
    pos_z_d = negz2_q ? -uvs_pkg::POS_W'(mz) : uvs_pkg::POS_W'(mz);
    if (!side_q[uvs_pkg::PIPE_DEPTH-2].vertex_valid) begin
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
    end
  end

  assign sum_y = {1'b0, py_q} + (uvs_pkg::PAIR_W + 1)'(1 << (uvs_pkg::SC2_SH - 1));

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < uvs_pkg::PIPE_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < uvs_pkg::PIPE_DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < uvs_pkg::PIPE_DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end

      // Divider.
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= uvs_pkg::REM_W'(num[l][uvs_pkg::NUM_W-1:uvs_pkg::QUOT_W]);
        sh_q[0][l]  <= num[l][uvs_pkg::QUOT_W-1:0];
        for (int s = 1; s < uvs_pkg::DIV_STAGES; s++) begin
          rem_q[s][l] <= rem_d[s-1][l];
        end
        for (int s = 1; s <= uvs_pkg::DIV_STAGES; s++) begin
          sh_q[s][l] <= sh_d[s-1][l];
        end
      end

      // Index, then the registered sine table read.
      for (int k = 0; k < 4; k++) begin
        idx_q[k]  <= idx_d[k];
        neg_q[k]  <= angle[k][uvs_pkg::ANGLE_BITS-1];
        sine_q[k] <= uvs_pkg::SINE_ROM[idx_q[k]];
        sneg_q[k] <= neg_q[k];
      end

      // First products.
      pxc_q   <= sine_q[LANE_SP] * sine_q[LANE_CT];
      pzc_q   <= sine_q[LANE_SP] * sine_q[LANE_ST];
      py_q    <= radius_q * sine_q[LANE_CP];
      negx1_q <= sneg_q[LANE_SP] ^ sneg_q[LANE_CT];
      negz1_q <= sneg_q[LANE_SP] ^ sneg_q[LANE_ST];
      negy1_q <= sneg_q[LANE_CP];

      // Radius times the sine pair; y is rounded here.
      prodx_q <= uvs_pkg::PX_W'(radius_q) * uvs_pkg::PX_W'(pxc_q);
      prodz_q <= uvs_pkg::PX_W'(radius_q) * uvs_pkg::PX_W'(pzc_q);
      magy_q  <= sum_y[uvs_pkg::SC2_SH +: uvs_pkg::MAG_W];
      negx2_q <= negx1_q;
      negy2_q <= negy1_q;
      negz2_q <= negz1_q;

      // Output register.
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  // Output word packing.
  always_comb begin
    out_data               = '0;
    out_data.pos_x         = pos_x_q;
    out_data.pos_y         = pos_y_q;
    out_data.pos_z         = pos_z_q;
    out_data.vertex_number = side_q[uvs_pkg::PIPE_DEPTH-1].vertex_number;
    out_data.corner_a      = side_q[uvs_pkg::PIPE_DEPTH-1].corner_a;
    out_data.corner_b      = side_q[uvs_pkg::PIPE_DEPTH-1].corner_b;
    out_data.corner_c      = side_q[uvs_pkg::PIPE_DEPTH-1].corner_c;
    out_data.corner_d      = side_q[uvs_pkg::PIPE_DEPTH-1].corner_d;
    out_user.vertex_valid  = side_q[uvs_pkg::PIPE_DEPTH-1].vertex_valid;
    out_user.cell_valid    = side_q[uvs_pkg::PIPE_DEPTH-1].cell_valid;
    out_user.config_error  = side_q[uvs_pkg::PIPE_DEPTH-1].config_error;
  end

  assign m_axis_tvalid = vld_q[uvs_pkg::PIPE_DEPTH-1];
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

endmodule

// ----- design/uvs_chk.sv -----
// ============================================================================
// uvs_chk: port checker of the UV sphere vertex generator
// Watches the stream ports and checks flag and index consistency of words.
// ============================================================================
module uvs_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [uvs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [uvs_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  uvs_pkg::out_data_t dq;
  uvs_pkg::out_user_t uq;

  assign dq = uvs_pkg::out_data_t'(m_axis_tdata);
  assign uq = uvs_pkg::out_user_t'(m_axis_tuser);

  // A stalled word holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // With the output register empty the block always takes a word.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A bad configuration yields no valid point and an all-zero word.
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && uq.config_error |->
      !uq.vertex_valid && !uq.cell_valid && (m_axis_tdata == '0))
    else $error("config error word not cleared");

  // A cell implies its vertex, and the right corners follow the left ones.
  a_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && uq.cell_valid |->
      uq.vertex_valid && (dq.corner_a == dq.vertex_number) &&
      (dq.corner_b == uvs_pkg::VIDX_W'(dq.corner_a + uvs_pkg::VIDX_W'(1))) &&
      (dq.corner_d == uvs_pkg::VIDX_W'(dq.corner_c + uvs_pkg::VIDX_W'(1))))
    else $error("cell corners inconsistent");

  // A point off the grid carries no position.
  a_offgrid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !uq.vertex_valid |->
      (dq.pos_x == '0) && (dq.pos_y == '0) && (dq.pos_z == '0) &&
      (dq.vertex_number == '0))
    else $error("off-grid point not cleared");

endmodule

bind uv_sphere_vertex_index_generator uvs_chk u_uvs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
